/* rtl/hsa_pkg.sv */
`default_nettype none

package hsa_pkg;

	localparam int TOP_COUNT_DEF  = 16;
	localparam int MID_COUNT_DEF  = 16;
	localparam int SLOT_COUNT_DEF = 16;

	localparam int DATA_W   = 16;
	localparam int IDX_W    = 4;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_WAS_FREE = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MID,
		ST_LEAF,
		ST_FREE
	} state_t;

	// how a finished request is closed out
	typedef enum logic [1:0] {
		FIN_FULL,
		FIN_ALLOC,
		FIN_FREE
	} fin_kind_t;

	typedef struct packed {
		logic      clr;
		logic      accept;
		logic      leaf_rd;
		logic      fin;
		fin_kind_t fin_kind;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic top_found;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

/* rtl/hierarchical_slot_allocator_top.sv */
// One request is in flight at a time: a new word is accepted only after the last result is
// written to the output register. An allocate reads the mid word, then the leaf word; a full
// reply ends after the mid-word read, and a free reads both words when its word is accepted.
// The next word is accepted while a result still waits in the output register.
// After arst_n a clearing pass over all TOP_COUNT*MID_COUNT leaf words fills
// the leaf and mid memories; s_tready stays low until it ends.
`default_nettype none

module hierarchical_slot_allocator_top #(
	parameter int TOP_COUNT  = hsa_pkg::TOP_COUNT_DEF,
	parameter int MID_COUNT  = hsa_pkg::MID_COUNT_DEF,
	parameter int SLOT_COUNT = hsa_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [hsa_pkg::DATA_W-1:0]   s_tdata,  // free_top, free_mid, free_slot
	input  wire logic                         s_tuser,  // req_type
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic      [hsa_pkg::DATA_W-1:0]   m_tdata,  // top_index, mid_index, slot_index
	output logic      [hsa_pkg::STATUS_W-1:0] m_tuser   // status
);

	hsa_pkg::cmd_t  cmd;
	hsa_pkg::stat_t stat;

	hsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hsa_datapath #(
		.TOP_COUNT  (TOP_COUNT),
		.MID_COUNT  (MID_COUNT),
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

/* rtl/hsa_rr_scan.sv */
`default_nettype none

// first set bit of row at or after start, wrapping around
module hsa_rr_scan #(
	parameter int N = 2,
	localparam int IW = $clog2(N)
) (
	input  wire logic [N-1:0]  row,
	input  wire logic [IW-1:0] start,
	output logic      [IW-1:0] idx,
	output logic               found
);

	logic [N-1:0]  masked;
	logic [IW-1:0] idx_hi;
	logic [IW-1:0] idx_lo;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			masked[i] = row[i] && (IW'(i) >= start);
		end
	end

	always_comb begin
		idx_hi = '0;
		idx_lo = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (masked[i]) begin
				idx_hi = IW'(i);
			end
			if (row[i]) begin
				idx_lo = IW'(i);
			end
		end
	end

	assign found = |row;
	assign idx   = (|masked) ? idx_hi : idx_lo;

endmodule

`default_nettype wire

/* rtl/hsa_ctrl.sv */
`default_nettype none

module hsa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          s_tuser,
	output logic               s_tready,
	input  wire hsa_pkg::stat_t stat,
	output hsa_pkg::cmd_t      cmd
);

	hsa_pkg::state_t state_q;
	hsa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hsa_pkg::ST_CLEAR: begin
				if (stat.clr_last) begin
					state_d = hsa_pkg::ST_IDLE;
				end
			end
			hsa_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = s_tuser ? hsa_pkg::ST_FREE : hsa_pkg::ST_MID;
				end
			end
			hsa_pkg::ST_MID: begin
				if (stat.top_found) begin
					state_d = hsa_pkg::ST_LEAF;
				end else if (stat.out_free) begin
					state_d = hsa_pkg::ST_IDLE;
				end
			end
			hsa_pkg::ST_LEAF, hsa_pkg::ST_FREE: begin
				if (stat.out_free) begin
					state_d = hsa_pkg::ST_IDLE;
				end
			end
			default: state_d = hsa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.clr      = 1'b0;
		cmd.accept   = 1'b0;
		cmd.leaf_rd  = 1'b0;
		cmd.fin      = 1'b0;
		cmd.fin_kind = hsa_pkg::FIN_FULL;
		unique case (state_q)
			hsa_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			hsa_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			hsa_pkg::ST_MID: begin
				cmd.leaf_rd  = stat.top_found;
				cmd.fin      = !stat.top_found && stat.out_free;
				cmd.fin_kind = hsa_pkg::FIN_FULL;
			end
			hsa_pkg::ST_LEAF: begin
				cmd.fin      = stat.out_free;
				cmd.fin_kind = hsa_pkg::FIN_ALLOC;
			end
			hsa_pkg::ST_FREE: begin
				cmd.fin      = stat.out_free;
				cmd.fin_kind = hsa_pkg::FIN_FREE;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/hsa_datapath.sv */
`default_nettype none

module hsa_datapath #(
	parameter int TOP_COUNT  = hsa_pkg::TOP_COUNT_DEF,
	parameter int MID_COUNT  = hsa_pkg::MID_COUNT_DEF,
	parameter int SLOT_COUNT = hsa_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hsa_pkg::cmd_t                 cmd,
	output hsa_pkg::stat_t                     stat,
	input  wire logic [hsa_pkg::DATA_W-1:0]    s_tdata,
	input  wire logic                          s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [hsa_pkg::DATA_W-1:0]    m_tdata,
	output logic      [hsa_pkg::STATUS_W-1:0]  m_tuser
);

	localparam int TW         = $clog2(TOP_COUNT);
	localparam int MW         = $clog2(MID_COUNT);
	localparam int SW         = $clog2(SLOT_COUNT);
	localparam int LEAF_COUNT = TOP_COUNT * MID_COUNT;
	localparam int LAW        = $clog2(LEAF_COUNT);
	localparam int MID_WW     = MW + MID_COUNT;
	localparam int LEAF_WW    = SW + SLOT_COUNT;
	localparam int IW         = hsa_pkg::IDX_W;

	// mid word: {cursor, has-room row}; leaf word: {cursor, free bits}
	logic [MID_WW-1:0]  mid_mem [TOP_COUNT];
	logic [LEAF_WW-1:0] leaf_mem [LEAF_COUNT];
	logic [MID_WW-1:0]  mid_rd_q;
	logic [LEAF_WW-1:0] leaf_rd_q;

	logic [TOP_COUNT-1:0] top_room_q;
	logic [TW-1:0]        top_cur_q;
	logic [LAW-1:0]       clr_idx_q;

	logic [TW-1:0] t_q;
	logic [MW-1:0] m_q;
	logic [SW-1:0] s_q;
	logic          top_found_q;
	logic          mid_found_q;
	logic          range_ok_q;

	logic                       out_valid_q;
	logic [hsa_pkg::STATUS_W-1:0] out_status_q;
	logic [IW-1:0]              out_top_q;
	logic [IW-1:0]              out_mid_q;
	logic [IW-1:0]              out_slot_q;

	logic [15:0]   ft_ext;
	logic [15:0]   fm_ext;
	logic [15:0]   fs_ext;
	logic          in_range;
	logic [TW-1:0] free_t;
	logic [MW-1:0] free_m;
	logic [SW-1:0] free_s;

	logic [TW-1:0] t_sel;
	logic          t_found;
	logic [MW-1:0] m_sel;
	logic          m_found;
	logic [SW-1:0] s_sel;
	logic          s_found;

	logic [MID_COUNT-1:0]  mid_row;
	logic [MW-1:0]         mid_cur;
	logic [SLOT_COUNT-1:0] slot_bits;
	logic [SW-1:0]         slot_cur;

	logic [LAW-1:0] free_leaf;
	logic [LAW-1:0] base_leaf;
	logic [LAW-1:0] cur_leaf;
	logic [LAW-1:0] leaf_raddr;
	logic           leaf_re;
	logic [TW-1:0]  mid_raddr;

	logic [SLOT_COUNT-1:0] taken_bits;
	logic                  leaf_now_full;
	logic [MID_COUNT-1:0]  alloc_row;
	logic [SLOT_COUNT-1:0] freed_bits;
	logic [MID_COUNT-1:0]  freed_row;
	logic                  already_free;
	logic                  alloc_ok;
	logic                  free_ok;
	logic                  fin_alloc;
	logic                  fin_free;
	logic                  grant;
	logic [hsa_pkg::STATUS_W-1:0] fin_status;

	logic               leaf_we;
	logic [LAW-1:0]     leaf_wa;
	logic [LEAF_WW-1:0] leaf_wd;
	logic               mid_we;
	logic [TW-1:0]      mid_wa;
	logic [MID_WW-1:0]  mid_wd;

	logic [15:0] t_out_ext;
	logic [15:0] m_out_ext;
	logic [15:0] s_out_ext;

	// request decode
	assign ft_ext   = 16'(s_tdata[3:0]);
	assign fm_ext   = 16'(s_tdata[7:4]);
	assign fs_ext   = 16'(s_tdata[11:8]);
	assign in_range = (9'(s_tdata[3:0]) < 9'(TOP_COUNT)) &&
		(9'(s_tdata[7:4]) < 9'(MID_COUNT)) &&
		(9'(s_tdata[11:8]) < 9'(SLOT_COUNT));
	assign free_t   = ft_ext[TW-1:0];
	assign free_m   = fm_ext[MW-1:0];
	assign free_s   = fs_ext[SW-1:0];

	assign mid_row   = mid_rd_q[MID_COUNT-1:0];
	assign mid_cur   = mid_rd_q[MID_WW-1:MID_COUNT];
	assign slot_bits = leaf_rd_q[SLOT_COUNT-1:0];
	assign slot_cur  = leaf_rd_q[LEAF_WW-1:SLOT_COUNT];

	hsa_rr_scan #(.N(TOP_COUNT)) u_top_scan (
		.row   (top_room_q),
		.start (top_cur_q),
		.idx   (t_sel),
		.found (t_found)
	);

	hsa_rr_scan #(.N(MID_COUNT)) u_mid_scan (
		.row   (mid_row),
		.start (mid_cur),
		.idx   (m_sel),
		.found (m_found)
	);

	hsa_rr_scan #(.N(SLOT_COUNT)) u_slot_scan (
		.row   (slot_bits),
		.start (slot_cur),
		.idx   (s_sel),
		.found (s_found)
	);

	assign free_leaf  = LAW'(free_t) * LAW'(MID_COUNT) + LAW'(free_m);
	assign base_leaf  = LAW'(t_q) * LAW'(MID_COUNT);
	assign cur_leaf   = base_leaf + LAW'(m_q);
	assign leaf_raddr = cmd.accept ? free_leaf : base_leaf + LAW'(m_sel);
	assign leaf_re    = (cmd.accept && s_tuser) || cmd.leaf_rd;
	assign mid_raddr  = s_tuser ? free_t : t_sel;

	// commit math
	assign taken_bits    = slot_bits & ~(SLOT_COUNT'(1) << s_sel);
	assign leaf_now_full = (taken_bits == '0);
	assign alloc_row     = leaf_now_full ? (mid_row & ~(MID_COUNT'(1) << m_q)) : mid_row;
	assign freed_bits    = slot_bits | (SLOT_COUNT'(1) << s_q);
	assign freed_row     = mid_row | (MID_COUNT'(1) << m_q);
	assign already_free  = slot_bits[s_q];
	assign alloc_ok      = mid_found_q && s_found;
	assign free_ok       = range_ok_q && !already_free;
	assign fin_alloc     = cmd.fin && (cmd.fin_kind == hsa_pkg::FIN_ALLOC);
	assign fin_free      = cmd.fin && (cmd.fin_kind == hsa_pkg::FIN_FREE);
	assign grant         = fin_alloc && alloc_ok;

	always_comb begin
		leaf_we = 1'b0;
		leaf_wa = cur_leaf;
		leaf_wd = {slot_cur, freed_bits};
		mid_we  = 1'b0;
		mid_wa  = t_q;
		mid_wd  = {mid_cur, freed_row};
		if (cmd.clr) begin
			leaf_we = 1'b1;
			leaf_wa = clr_idx_q;
			leaf_wd = {{SW{1'b0}}, {SLOT_COUNT{1'b1}}};
			mid_we  = (clr_idx_q < LAW'(TOP_COUNT));
			mid_wa  = clr_idx_q[TW-1:0];
			mid_wd  = {{MW{1'b0}}, {MID_COUNT{1'b1}}};
		end else if (fin_alloc) begin
			leaf_we = alloc_ok;
			leaf_wd = {s_sel, taken_bits};
			mid_we  = alloc_ok;
			mid_wd  = {m_q, alloc_row};
		end else if (fin_free) begin
			leaf_we = free_ok;
			mid_we  = free_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (leaf_we) begin
			leaf_mem[leaf_wa] <= leaf_wd;
		end
		if (leaf_re) begin
			leaf_rd_q <= leaf_mem[leaf_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (mid_we) begin
			mid_mem[mid_wa] <= mid_wd;
		end
		if (cmd.accept) begin
			mid_rd_q <= mid_mem[mid_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_room_q  <= '1;
			top_cur_q   <= '0;
			clr_idx_q   <= '0;
			top_found_q <= 1'b0;
			mid_found_q <= 1'b0;
			range_ok_q  <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cmd.accept) begin
				top_found_q <= t_found;
				range_ok_q  <= in_range;
			end
			if (cmd.leaf_rd) begin
				mid_found_q <= m_found;
			end
			if (fin_alloc && alloc_ok) begin
				top_cur_q <= t_q;
				if (leaf_now_full && (alloc_row == '0)) begin
					top_room_q[t_q] <= 1'b0;
				end
			end
			if (fin_free && free_ok) begin
				top_room_q[t_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			t_q <= s_tuser ? free_t : t_sel;
			m_q <= free_m;
			s_q <= free_s;
		end
		if (cmd.leaf_rd) begin
			m_q <= m_sel;
		end
	end

	// result register
	assign t_out_ext = 16'(t_q);
	assign m_out_ext = 16'(m_q);
	assign s_out_ext = 16'(s_sel);

	always_comb begin
		fin_status = hsa_pkg::STATUS_OK;
		unique case (cmd.fin_kind)
			hsa_pkg::FIN_ALLOC: begin
				if (!alloc_ok) begin
					fin_status = hsa_pkg::STATUS_FULL;
				end
			end
			hsa_pkg::FIN_FREE: begin
				if (range_ok_q && already_free) begin
					fin_status = hsa_pkg::STATUS_WAS_FREE;
				end
			end
			default: begin
				fin_status = hsa_pkg::STATUS_FULL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_status_q <= fin_status;
			out_top_q    <= grant ? t_out_ext[IW-1:0] : '0;
			out_mid_q    <= grant ? m_out_ext[IW-1:0] : '0;
			out_slot_q   <= grant ? s_out_ext[IW-1:0] : '0;
		end
	end

	assign stat.clr_last  = (clr_idx_q == LAW'(LEAF_COUNT - 1));
	assign stat.top_found = top_found_q;
	assign stat.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'b0000, out_slot_q, out_mid_q, out_top_q};

endmodule

`default_nettype wire
